// ===== design/lbr_pkg.sv =====
// Shared constants, types and helper functions of the letterbox bilinear resizer.
// Used by the top level, the divider, the datapath and the controller; depends on nothing.
package lbr_pkg;

	localparam int MAX_SRC_WIDTH  = 640;
	localparam int MAX_SRC_HEIGHT = 480;
	localparam int MAX_TARGET     = 256;
	localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int STORE_AW       = $clog2(STORE_DEPTH);
	localparam int PIX_W          = 24;
	localparam int DIV_NW         = 27;
	localparam int DIV_DW         = 11;
	localparam int SCALE_W        = 26;

	typedef enum logic [1:0] {
		REG_SRC_WIDTH   = 2'd0,
		REG_SRC_HEIGHT  = 2'd1,
		REG_TARGET_SIZE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		DIV_SCALE = 2'd0,
		DIV_NEW_W = 2'd1,
		DIV_NEW_H = 2'd2
	} div_sel_t;

	typedef enum logic [1:0] {
		RD_P00 = 2'd0,
		RD_P10 = 2'd1,
		RD_P01 = 2'd2,
		RD_P11 = 2'd3
	} rd_sel_t;

	typedef enum logic [4:0] {
		ST_SETUP_SCALE,
		ST_WAIT_SCALE,
		ST_SETUP_NEW_W,
		ST_WAIT_NEW_W,
		ST_SETUP_NEW_H,
		ST_WAIT_NEW_H,
		ST_PAD,
		ST_BIAS,
		ST_IDLE,
		ST_MUL,
		ST_ROW,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_RD4,
		ST_HORZ,
		ST_VERT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic     load_we;
		logic     sample_start;
		logic     div_start;
		logic     div_capture;
		div_sel_t div_sel;
		logic     pad_calc;
		logic     bias_calc;
		logic     mul_en;
		logic     row_en;
		rd_sel_t  rd_sel;
		logic     pix_shift;
		logic     horz_en;
		logic     vert_en;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic in_pic;
		logic out_free;
	} dp_stat_t;

	// zero counts as one, anything above the maximum counts as the maximum
	function automatic logic [9:0] clamp_width(input logic [9:0] v);
		if (v == 10'd0) return 10'd1;
		if (v > 10'(MAX_SRC_WIDTH)) return 10'(MAX_SRC_WIDTH);
		return v;
	endfunction

	function automatic logic [8:0] clamp_height(input logic [8:0] v);
		if (v == 9'd0) return 9'd1;
		if (v > 9'(MAX_SRC_HEIGHT)) return 9'(MAX_SRC_HEIGHT);
		return v;
	endfunction

	function automatic logic [8:0] clamp_target(input logic [8:0] v);
		if (v == 9'd0) return 9'd1;
		if (v > 9'(MAX_TARGET)) return 9'(MAX_TARGET);
		return v;
	endfunction

endpackage

// ===== design/lbr_in_if.sv =====
// Input channel of the resizer: valid/ready handshake plus load or sample payload.
// No dependencies.
interface lbr_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] out_x;
	logic [7:0] out_y;

	modport source(output valid, command, red, green, blue, out_x, out_y, input ready);
	modport sink(input valid, command, red, green, blue, out_x, out_y, output ready);
endinterface

// ===== design/lbr_out_if.sv =====
// Result channel of the resizer: valid/ready handshake plus resampled pixel.
// No dependencies.
interface lbr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       is_padding;
	logic [8:0] pad_bias_x;
	logic [8:0] pad_bias_y;

	modport source(output valid, red_out, green_out, blue_out, is_padding, pad_bias_x,
		pad_bias_y, input ready);
	modport sink(input valid, red_out, green_out, blue_out, is_padding, pad_bias_x,
		pad_bias_y, output ready);
endinterface

// ===== design/letterbox_bilinear_resize.sv =====
// Top level of the letterbox bilinear resizer: controller plus datapath.
// Depends on lbr_pkg, lbr_in_if, lbr_out_if, lbr_ctrl, lbr_datapath.
//
//  channel | dir | beat carries
//  --------+-----+---------------------------------------------------------
//  pixel   | in  | command, red, green, blue, out_x, out_y
//  result  | out | red_out, green_out, blue_out, is_padding, pad_bias_x/y
//  cfg     | in  | cfg_wr_en, cfg_index, cfg_data (write only)
//
// Loads stream at one per clock while the controller is idle.
// After a sample the next beat waits until its result is loaded; padding goes from the
// first multiply stage to the output, others pass two multiply stages, four reads on
// the single frame store port and two blend stages. After reset and every cfg write
// three divisions (27 quotient bits each) rebuild the geometry, with pixel.ready low.
// A waiting result stalls only the next sample at its final stage.
module letterbox_bilinear_resize import lbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lbr_in_if.sink     pixel,
	lbr_out_if.source  result,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	lbr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.in_valid   (pixel.valid),
		.in_command (pixel.command),
		.in_ready   (pixel.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	lbr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_red    (pixel.red),
		.in_green  (pixel.green),
		.in_blue   (pixel.blue),
		.in_x      (pixel.out_x),
		.in_y      (pixel.out_y),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

	a_sample_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready && pixel.command == CMD_SAMPLE) |=> !pixel.ready)
		else $error("input taken while a sample is in flight");

	a_cfg_resetup: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> !pixel.ready)
		else $error("input taken before geometry rebuilt");

	a_pad_black: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.is_padding) |->
		(result.red_out == 8'd0 && result.green_out == 8'd0 && result.blue_out == 8'd0))
		else $error("padding result with nonzero color");

	a_bias_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.pad_bias_x <= 9'd320 && result.pad_bias_y <= 9'd320))
		else $error("pad bias out of range");
endmodule

// ===== design/lbr_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module lbr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== design/lbr_div.sv =====
// Restoring divider, one quotient bit per cycle; used for scale and fitted size.
// Depends on lbr_pkg.
module lbr_div import lbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic [DIV_NW-1:0] quotient,
	output logic              done
);
	localparam int CW = $clog2(DIV_NW);

	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DW'(trial - {1'b0, dvs_q}) : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

// ===== design/lbr_datapath.sv =====
// Datapath: config registers, derived geometry, write pointer, frame store,
// coordinate mapping, bilinear blend and the result register.
// Depends on lbr_pkg, lbr_out_if, lbr_ram, lbr_div.
module lbr_datapath import lbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic [7:0] in_red,
	input  logic [7:0] in_green,
	input  logic [7:0] in_blue,
	input  logic [7:0] in_x,
	input  logic [7:0] in_y,
	input  ctrl_cmd_t  cmd,
	output dp_stat_t   stat,
	lbr_out_if.source  result
);
	logic [9:0] src_width_q;
	logic [8:0] src_height_q;
	logic [8:0] target_q;
	logic [9:0] w;
	logic [8:0] h;
	logic [8:0] t;
	logic [9:0] m;
	logic [STORE_AW-1:0] frame;

	assign w = clamp_width(src_width_q);
	assign h = clamp_height(src_height_q);
	assign t = clamp_target(target_q);
	assign m = (w > {1'b0, h}) ? w : {1'b0, h};
	assign frame = STORE_AW'(STORE_AW'(w) * STORE_AW'(h));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 10'(MAX_SRC_WIDTH);
			src_height_q <= 9'(MAX_SRC_HEIGHT);
			target_q     <= 9'(MAX_TARGET);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:   src_width_q  <= cfg_data;
				REG_SRC_HEIGHT:  src_height_q <= cfg_data[8:0];
				REG_TARGET_SIZE: target_q     <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// derived geometry
	logic [DIV_NW-1:0]  div_num;
	logic [DIV_DW-1:0]  div_den;
	logic [DIV_NW-1:0]  div_quo;
	logic               div_done;
	logic [8:0]         fit;
	logic [SCALE_W-1:0] scale_q;
	logic [8:0]         new_w_q;
	logic [8:0]         new_h_q;
	logic [7:0]         pad_x_q;
	logic [7:0]         pad_y_q;
	logic [8:0]         bias_x_q;
	logic [8:0]         bias_y_q;
	logic [8:0]         pad_x_d;
	logic [8:0]         pad_y_d;
	logic [33:0]        bias_x_d;
	logic [33:0]        bias_y_d;

	always_comb begin
		case (cmd.div_sel)
			DIV_SCALE: begin
				div_num = DIV_NW'({m, 16'd0});
				div_den = DIV_DW'(t);
			end
			DIV_NEW_W: begin
				div_num = DIV_NW'(DIV_NW'({w, 1'b0}) * DIV_NW'(t)) + DIV_NW'(m);
				div_den = {m, 1'b0};
			end
			DIV_NEW_H: begin
				div_num = DIV_NW'(DIV_NW'({h, 1'b0}) * DIV_NW'(t)) + DIV_NW'(m);
				div_den = {m, 1'b0};
			end
			default: begin
				div_num = DIV_NW'({m, 16'd0});
				div_den = DIV_DW'(t);
			end
		endcase
	end

	lbr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_quo),
		.done     (div_done)
	);

	assign fit      = (div_quo > DIV_NW'(t)) ? t : div_quo[8:0];
	assign pad_x_d  = 9'(t - new_w_q);
	assign pad_y_d  = 9'(t - new_h_q);
	assign bias_x_d = 34'(pad_x_q) * 34'(scale_q) + 34'd32768;
	assign bias_y_d = 34'(pad_y_q) * 34'(scale_q) + 34'd32768;

	always_ff @(posedge clk) begin
		if (cmd.div_capture) begin
			case (cmd.div_sel)
				DIV_SCALE: scale_q <= div_quo[SCALE_W-1:0];
				DIV_NEW_W: new_w_q <= fit;
				DIV_NEW_H: new_h_q <= fit;
				default: ;
			endcase
		end
		if (cmd.pad_calc) begin
			pad_x_q <= pad_x_d[8:1];
			pad_y_q <= pad_y_d[8:1];
		end
		if (cmd.bias_calc) begin
			bias_x_q <= bias_x_d[24:16];
			bias_y_q <= bias_y_d[24:16];
		end
	end

	// write pointer; wraps to zero at the frame end and restarts at zero when the frame shrank below it
	logic [STORE_AW-1:0] wp_q;
	logic [STORE_AW-1:0] wr_addr;
	logic [STORE_AW-1:0] wp_next;

	assign wr_addr = (wp_q >= frame) ? '0 : wp_q;
	assign wp_next = wr_addr + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (cmd.load_we) begin
			wp_q <= (wp_next >= frame) ? '0 : wp_next;
		end
	end

	// coordinate mapping
	logic [7:0]  ox_q;
	logic [7:0]  oy_q;
	logic        inside_q;
	logic        inside_c;
	logic [7:0]  rel_x;
	logic [7:0]  rel_y;
	logic [7:0]  in_rel_x;
	logic [7:0]  in_rel_y;
	logic [33:0] sx_q;
	logic [33:0] sy_q;

	assign in_rel_x = in_x - pad_x_q;
	assign in_rel_y = in_y - pad_y_q;
	assign inside_c = ({1'b0, in_x} < t) && ({1'b0, in_y} < t)
		&& (in_x >= pad_x_q) && (in_y >= pad_y_q)
		&& ({1'b0, in_rel_x} < new_w_q) && ({1'b0, in_rel_y} < new_h_q);
	assign rel_x = ox_q - pad_x_q;
	assign rel_y = oy_q - pad_y_q;

	always_ff @(posedge clk) begin
		if (cmd.sample_start) begin
			ox_q     <= in_x;
			oy_q     <= in_y;
			inside_q <= inside_c;
		end
		if (cmd.mul_en) begin
			sx_q <= 34'(rel_x) * 34'(scale_q);
			sy_q <= 34'(rel_y) * 34'(scale_q);
		end
	end

	logic [25:0]         lim_x;
	logic [24:0]         lim_y;
	logic [25:0]         sxc;
	logic [24:0]         syc;
	logic [9:0]          x0;
	logic [8:0]          y0;
	logic [9:0]          x1;
	logic [8:0]          y1;
	logic [9:0]          x0_q;
	logic [9:0]          x1_q;
	logic [7:0]          wx_q;
	logic [7:0]          wy_q;
	logic [STORE_AW-1:0] row0_q;
	logic [STORE_AW-1:0] row1_q;

	assign lim_x = {10'(w - 10'd1), 16'd0};
	assign lim_y = {9'(h - 9'd1), 16'd0};
	assign sxc   = (sx_q > 34'(lim_x)) ? lim_x : sx_q[25:0];
	assign syc   = (sy_q > 34'(lim_y)) ? lim_y : sy_q[24:0];
	assign x0    = sxc[25:16];
	assign y0    = syc[24:16];
	assign x1    = (({1'b0, x0} + 11'd1) < {1'b0, w}) ? 10'(x0 + 10'd1) : 10'(w - 10'd1);
	assign y1    = (({1'b0, y0} + 10'd1) < {1'b0, h}) ? 9'(y0 + 9'd1) : 9'(h - 9'd1);

	always_ff @(posedge clk) begin
		if (cmd.row_en) begin
			x0_q   <= x0;
			x1_q   <= x1;
			wx_q   <= sxc[15:8];
			wy_q   <= syc[15:8];
			row0_q <= STORE_AW'(STORE_AW'(y0) * STORE_AW'(w));
			row1_q <= STORE_AW'(STORE_AW'(y1) * STORE_AW'(w));
		end
	end

	// frame store
	logic [STORE_AW-1:0] rd_addr;
	logic [STORE_AW-1:0] ram_addr;
	logic [PIX_W-1:0]    ram_rdata;

	always_comb begin
		case (cmd.rd_sel)
			RD_P00:  rd_addr = row0_q + STORE_AW'(x0_q);
			RD_P10:  rd_addr = row0_q + STORE_AW'(x1_q);
			RD_P01:  rd_addr = row1_q + STORE_AW'(x0_q);
			RD_P11:  rd_addr = row1_q + STORE_AW'(x1_q);
			default: rd_addr = row0_q + STORE_AW'(x0_q);
		endcase
	end

	assign ram_addr = cmd.load_we ? wr_addr : rd_addr;

	lbr_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_frame_store (
		.clk   (clk),
		.we    (cmd.load_we),
		.addr  (ram_addr),
		.wdata ({in_red, in_green, in_blue}),
		.rdata (ram_rdata)
	);

	// neighbors arrive as p00, p10, p01, p11 and shift down into place
	logic [PIX_W-1:0] pix_q [4];

	always_ff @(posedge clk) begin
		if (cmd.pix_shift) begin
			pix_q[0] <= pix_q[1];
			pix_q[1] <= pix_q[2];
			pix_q[2] <= pix_q[3];
			pix_q[3] <= ram_rdata;
		end
	end

	// blend: horizontal in Q8, then vertical to Q16; lane 2 is red, lane 0 blue
	logic [8:0]  iwx;
	logic [8:0]  iwy;
	logic [15:0] top_d [3];
	logic [15:0] bot_d [3];
	logic [15:0] top_q [3];
	logic [15:0] bot_q [3];
	logic [23:0] mix_d [3];
	logic [23:0] mix_q [3];
	logic [24:0] rnd   [3];
	logic [7:0]  chan  [3];

	assign iwx = 9'(9'd256 - {1'b0, wx_q});
	assign iwy = 9'(9'd256 - {1'b0, wy_q});

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			top_d[c] = 16'(16'(pix_q[0][8*c +: 8]) * 16'(iwx))
				+ 16'(16'(pix_q[1][8*c +: 8]) * 16'(wx_q));
			bot_d[c] = 16'(16'(pix_q[2][8*c +: 8]) * 16'(iwx))
				+ 16'(16'(pix_q[3][8*c +: 8]) * 16'(wx_q));
			mix_d[c] = 24'(24'(top_q[c]) * 24'(iwy)) + 24'(24'(bot_q[c]) * 24'(wy_q));
			rnd[c]   = 25'(mix_q[c]) + 25'd32768;
			chan[c]  = (rnd[c][24:16] > 9'd255) ? 8'd255 : rnd[c][23:16];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (cmd.horz_en) begin
				top_q[c] <= top_d[c];
				bot_q[c] <= bot_d[c];
			end
			if (cmd.vert_en) begin
				mix_q[c] <= mix_d[c];
			end
		end
	end

	// result register
	logic       out_valid_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic       pad_q;
	logic [8:0] obx_q;
	logic [8:0] oby_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			red_q   <= inside_q ? chan[2] : 8'd0;
			green_q <= inside_q ? chan[1] : 8'd0;
			blue_q  <= inside_q ? chan[0] : 8'd0;
			pad_q   <= !inside_q;
			obx_q   <= bias_x_q;
			oby_q   <= bias_y_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.red_out    = red_q;
	assign result.green_out  = green_q;
	assign result.blue_out   = blue_q;
	assign result.is_padding = pad_q;
	assign result.pad_bias_x = obx_q;
	assign result.pad_bias_y = oby_q;

	assign stat.div_done = div_done;
	assign stat.in_pic   = inside_q;
	assign stat.out_free = !out_valid_q || result.ready;
endmodule

// ===== design/lbr_ctrl.sv =====
// Controller: geometry setup after reset and config writes, then the
// per-item sequence for loads and samples.
// Depends on lbr_pkg.
module lbr_ctrl import lbr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      in_valid,
	input  logic      in_command,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);
	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SETUP_SCALE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_SETUP_SCALE: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SCALE;
				state_d       = ST_WAIT_SCALE;
			end
			ST_WAIT_SCALE: begin
				cmd.div_sel = DIV_SCALE;
				if (stat.div_done) begin
					cmd.div_capture = 1'b1;
					state_d         = ST_SETUP_NEW_W;
				end
			end
			ST_SETUP_NEW_W: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_NEW_W;
				state_d       = ST_WAIT_NEW_W;
			end
			ST_WAIT_NEW_W: begin
				cmd.div_sel = DIV_NEW_W;
				if (stat.div_done) begin
					cmd.div_capture = 1'b1;
					state_d         = ST_SETUP_NEW_H;
				end
			end
			ST_SETUP_NEW_H: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_NEW_H;
				state_d       = ST_WAIT_NEW_H;
			end
			ST_WAIT_NEW_H: begin
				cmd.div_sel = DIV_NEW_H;
				if (stat.div_done) begin
					cmd.div_capture = 1'b1;
					state_d         = ST_PAD;
				end
			end
			ST_PAD: begin
				cmd.pad_calc = 1'b1;
				state_d      = ST_BIAS;
			end
			ST_BIAS: begin
				cmd.bias_calc = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_command == CMD_SAMPLE) begin
						cmd.sample_start = 1'b1;
						state_d          = ST_MUL;
					end else begin
						cmd.load_we = 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = stat.in_pic ? ST_ROW : ST_OUT;
			end
			ST_ROW: begin
				cmd.row_en = 1'b1;
				state_d    = ST_RD0;
			end
			ST_RD0: begin
				cmd.rd_sel = RD_P00;
				state_d    = ST_RD1;
			end
			ST_RD1: begin
				cmd.rd_sel    = RD_P10;
				cmd.pix_shift = 1'b1;
				state_d       = ST_RD2;
			end
			ST_RD2: begin
				cmd.rd_sel    = RD_P01;
				cmd.pix_shift = 1'b1;
				state_d       = ST_RD3;
			end
			ST_RD3: begin
				cmd.rd_sel    = RD_P11;
				cmd.pix_shift = 1'b1;
				state_d       = ST_RD4;
			end
			ST_RD4: begin
				cmd.pix_shift = 1'b1;
				state_d       = ST_HORZ;
			end
			ST_HORZ: begin
				cmd.horz_en = 1'b1;
				state_d     = ST_VERT;
			end
			ST_VERT: begin
				cmd.vert_en = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_SETUP_SCALE;
		endcase
		// new geometry after any register write
		if (cfg_wr_en) begin
			state_d = ST_SETUP_SCALE;
		end
	end
endmodule

// ===== dv/lbr_tb_if.sv =====
// Testbench copies are not needed: the design's interfaces lbr_in_if and lbr_out_if are used.
// This file holds the beat record types shared by the driver and the checker; depends on lbr_pkg.
package lbr_tb_pkg;
	import lbr_pkg::*;

	typedef struct {
		cmd_t       command;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] out_x;
		logic [7:0] out_y;
	} pixel_beat_t;

	typedef struct {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       is_padding;
		logic [8:0] pad_bias_x;
		logic [8:0] pad_bias_y;
	} result_beat_t;
endpackage

// ===== dv/tb_letterbox_bilinear_resize.sv =====
// Testbench of letterbox_bilinear_resize: loads small frames, samples the letterboxed output
// and checks every result against an in-bench bilinear predictor. Depends on lbr_pkg, lbr_tb_pkg.
module tb_letterbox_bilinear_resize;
	import lbr_pkg::*;
	import lbr_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;

	lbr_in_if pixel();
	lbr_out_if result();

	letterbox_bilinear_resize u_top (
		.clk(clk), .arst_n(arst_n), .pixel(pixel), .result(result),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [23:0] frame_mem [STORE_DEPTH];
	int unsigned wr_ptr;
	int unsigned reg_w, reg_h, reg_t;

	pixel_beat_t  pending_beats[$];
	result_beat_t expected_results[$];
	int errors = 0;
	int n_results = 0, n_padding = 0, n_phases = 0;
	bit hold_off = 1'b0;

	function automatic int unsigned clampv(int unsigned v, int unsigned mx);
		if (v == 0) return 1;
		if (v > mx) return mx;
		return v;
	endfunction

	function automatic logic [7:0] mix_channel(int unsigned a0, a1, b0, b1, wx, wy);
		longint unsigned top, bot, v;
		top = a0 * (256 - wx) + a1 * wx;
		bot = b0 * (256 - wx) + b1 * wx;
		v = (top * (256 - wy) + bot * wy + 32768) >> 16;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic logic [23:0] fetch(int unsigned x, y, w);
		int unsigned idx;
		idx = y * w + x;
		return (idx >= STORE_DEPTH) ? 24'd0 : frame_mem[idx];
	endfunction

	// applies one accepted beat to the predictor, queues a result for samples
	task automatic predict_beat(input pixel_beat_t b);
		int unsigned w, h, t, m, nw, nh, px, py, ox, oy, x0, y0, x1, y1, wx, wy;
		longint unsigned scale, sx, sy;
		logic [23:0] p00, p10, p01, p11;
		result_beat_t r;
		w = clampv(reg_w, MAX_SRC_WIDTH);
		h = clampv(reg_h, MAX_SRC_HEIGHT);
		t = clampv(reg_t, MAX_TARGET);
		if (b.command == CMD_LOAD) begin
			if (wr_ptr >= w * h) wr_ptr = 0;
			frame_mem[wr_ptr] = {b.red, b.green, b.blue};
			wr_ptr = (wr_ptr + 1) & 32'h7FFFF;
			if (wr_ptr >= w * h) wr_ptr = 0;
			return;
		end
		m = (w > h) ? w : h;
		scale = (longint'(m) << 16) / t;
		nw = (2 * w * t + m) / (2 * m);
		nh = (2 * h * t + m) / (2 * m);
		if (nw > t) nw = t;
		if (nh > t) nh = t;
		px = (t - nw) / 2;
		py = (t - nh) / 2;
		r.pad_bias_x = 9'((px * scale + 32768) >> 16);
		r.pad_bias_y = 9'((py * scale + 32768) >> 16);
		ox = b.out_x;
		oy = b.out_y;
		r.red_out = 0; r.green_out = 0; r.blue_out = 0; r.is_padding = 1'b1;
		if (ox < t && oy < t && ox >= px && oy >= py && ox - px < nw && oy - py < nh) begin
			sx = (ox - px) * scale;
			sy = (oy - py) * scale;
			if (sx > (longint'(w - 1) << 16)) sx = longint'(w - 1) << 16;
			if (sy > (longint'(h - 1) << 16)) sy = longint'(h - 1) << 16;
			x0 = sx >> 16;
			y0 = sy >> 16;
			x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
			y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
			wx = (sx >> 8) & 8'hFF;
			wy = (sy >> 8) & 8'hFF;
			p00 = fetch(x0, y0, w); p10 = fetch(x1, y0, w);
			p01 = fetch(x0, y1, w); p11 = fetch(x1, y1, w);
			r.red_out = mix_channel(p00[23:16], p10[23:16], p01[23:16], p11[23:16], wx, wy);
			r.green_out = mix_channel(p00[15:8], p10[15:8], p01[15:8], p11[15:8], wx, wy);
			r.blue_out = mix_channel(p00[7:0], p10[7:0], p01[7:0], p11[7:0], wx, wy);
			r.is_padding = 1'b0;
			n_results++;
		end else begin
			n_padding++;
		end
		expected_results.push_back(r);
	endtask

	// driver: one beat from the queue at a time, random gap before each
	int gap_left = 0;
	pixel_beat_t cur_beat;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel.valid <= 1'b0;
			pixel.command <= 1'b0;
			{pixel.red, pixel.green, pixel.blue, pixel.out_x, pixel.out_y} <= '0;
		end else begin
			if (pixel.valid && pixel.ready) begin
				predict_beat(cur_beat);
				gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			end
			if (pixel.valid && !pixel.ready) begin
				// keep offering
			end else if (gap_left > 0) begin
				gap_left--;
				pixel.valid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				cur_beat = pending_beats.pop_front();
				pixel.valid <= 1'b1;
				pixel.command <= cur_beat.command;
				pixel.red <= cur_beat.red;
				pixel.green <= cur_beat.green;
				pixel.blue <= cur_beat.blue;
				pixel.out_x <= cur_beat.out_x;
				pixel.out_y <= cur_beat.out_y;
			end else begin
				pixel.valid <= 1'b0;
			end
		end
	end

	// monitor: random stalls on the result side, compare against oldest prediction
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					automatic result_beat_t e = expected_results.pop_front();
					if (result.red_out !== e.red_out) begin
						$error("red_out exp %0d got %0d", e.red_out, result.red_out); errors++;
					end
					if (result.green_out !== e.green_out) begin
						$error("green_out exp %0d got %0d", e.green_out, result.green_out); errors++;
					end
					if (result.blue_out !== e.blue_out) begin
						$error("blue_out exp %0d got %0d", e.blue_out, result.blue_out); errors++;
					end
					if (result.is_padding !== e.is_padding) begin
						$error("is_padding exp %0d got %0d", e.is_padding, result.is_padding);
						errors++;
					end
					if (result.pad_bias_x !== e.pad_bias_x) begin
						$error("pad_bias_x exp %0d got %0d", e.pad_bias_x, result.pad_bias_x);
						errors++;
					end
					if (result.pad_bias_y !== e.pad_bias_y) begin
						$error("pad_bias_y exp %0d got %0d", e.pad_bias_y, result.pad_bias_y);
						errors++;
					end
				end
				stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			end
			if (hold_off) begin
				result.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	task automatic push_load(input logic [7:0] r, g, b);
		pixel_beat_t p;
		p.command = CMD_LOAD; p.red = r; p.green = g; p.blue = b;
		p.out_x = 8'($urandom); p.out_y = 8'($urandom);
		pending_beats.push_back(p);
	endtask

	task automatic push_sample(input logic [7:0] x, y);
		pixel_beat_t p;
		p.command = CMD_SAMPLE; p.out_x = x; p.out_y = y;
		p.red = 8'($urandom); p.green = 8'($urandom); p.blue = 8'($urandom);
		pending_beats.push_back(p);
	endtask

	task automatic wait_drained();
		while (pending_beats.size() > 0 || pixel.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// idle-time register write; predictor follows immediately
	task automatic write_reg(input cfg_reg_t idx, input logic [9:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_SRC_WIDTH:   reg_w = v;
			REG_SRC_HEIGHT:  reg_h = v[8:0];
			REG_TARGET_SIZE: reg_t = v[8:0];
			default: ;
		endcase
	endtask

	// fills the whole effective frame so every sample reads written pixels
	task automatic load_frame(input int unsigned w, h);
		repeat (w * h) push_load(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic run_phase(input logic [9:0] w, h, t, input int n_samples, input bit raw_xy);
		int unsigned ew, eh;
		write_reg(REG_SRC_WIDTH, w);
		write_reg(REG_SRC_HEIGHT, h);
		write_reg(REG_TARGET_SIZE, t);
		ew = clampv(reg_w, MAX_SRC_WIDTH);
		eh = clampv(reg_h, MAX_SRC_HEIGHT);
		load_frame(ew, eh);
		repeat (n_samples) begin
			if (raw_xy || $urandom_range(0, 4) == 0)
				push_sample(8'($urandom), 8'($urandom));
			else
				push_sample(8'($urandom_range(0, clampv(reg_t, MAX_TARGET) - 1)),
					8'($urandom_range(0, clampv(reg_t, MAX_TARGET) - 1)));
			if ($urandom_range(0, 9) == 0)
				push_load(8'($urandom), 8'($urandom), 8'($urandom));
		end
		wait_drained();
		n_phases++;
	endtask

	initial begin
		reg_w = 640; reg_h = 480; reg_t = 256; wr_ptr = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: tiny frame, extreme pixel values, corners and beyond-target coordinates
		write_reg(REG_SRC_WIDTH, 10'd2);
		write_reg(REG_SRC_HEIGHT, 10'd2);
		write_reg(REG_TARGET_SIZE, 10'd4);
		push_load(8'hFF, 8'h00, 8'hFF);
		push_load(8'h00, 8'hFF, 8'h00);
		push_load(8'hAA, 8'h55, 8'h00);
		push_load(8'h55, 8'hAA, 8'hFF);
		push_sample(8'd0, 8'd0);
		push_sample(8'd3, 8'd3);
		push_sample(8'd1, 8'd2);
		push_sample(8'd4, 8'd0);
		push_sample(8'd255, 8'd255);
		push_sample(8'd0, 8'd255);
		wait_drained();

		// zero registers count as one; wide frame gives vertical padding
		run_phase(10'd0, 10'd0, 10'd0, 6, 1'b1);
		run_phase(10'd8, 10'd3, 10'd16, 12, 1'b0);
		run_phase(10'd3, 10'd7, 10'd255, 12, 1'b0);

		// long result-side hold-off while loads and samples keep coming
		hold_off = 1'b1;
		load_frame(3, 7);
		repeat (20) push_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		repeat (600) @(posedge clk);
		hold_off = 1'b0;
		wait_drained();

		// shrink the frame below the write pointer, then samples on new frame
		run_phase(10'd2, 10'd1, 10'd1, 8, 1'b1);

		// random phases; small frames
		repeat (4) run_phase(10'($urandom_range(1, 12)), 10'($urandom_range(1, 12)),
			10'($urandom_range(1, 256)), 20, 1'b0);

		// width and target above their maximum; one-row frame gives the widest padding
		run_phase(10'd1023, 10'd1, 10'd511, 20, 1'b0);

		$display("tb: %0d configurations, %0d picture and %0d padding samples checked",
			n_phases, n_results, n_padding);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#40000000;
		$display("tb: failure");
		$finish;
	end
endmodule
